### rtl/core/sorted_min_priority_queue_top_macros.svh
// assertion helpers for the queue rtl
`ifndef SORTED_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define SMPQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle implication checked outside reset
`define SMPQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/smpq_pkg.sv
package smpq_pkg;

	localparam int DEPTH = 8;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ROT_W = $clog2(DEPTH);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LIST   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_INSERTED = 3'd0,
		STAT_REMOVED  = 3'd1,
		STAT_LISTED   = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] item_value;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
		logic               last;
	} out_word_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] item;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LIST,
		ST_SPIN
	} state_t;

endpackage

### rtl/core/smpq_cell.sv
module smpq_cell
	import smpq_pkg::*;
(
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic               occupied,
	input  logic signed [31:0] left_val,
	input  logic               left_shift,
	input  logic signed [31:0] right_val,
	output logic signed [31:0] val,
	output logic               shift
);

	logic signed [31:0] val_q;
	logic signed [31:0] val_d;

	// an empty cell counts as greater than any new word
	assign shift = !occupied || (val_q > ctl.item);
	assign val   = val_q;

	always_comb begin
		val_d = val_q;
		case (ctl.op)
			CELL_INSERT: begin
				if (shift) begin
					val_d = left_shift ? left_val : ctl.item;
				end
			end
			CELL_SHIFT: val_d = right_val;
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

### rtl/core/smpq_ctrl.sv
module smpq_ctrl
	import smpq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output out_word_t          out_word,
	input  logic signed [31:0] head_val,
	output cell_ctl_t          cell_ctl,
	output logic [CNT_W-1:0]   occ
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] occ_q, occ_d;
	logic [ROT_W-1:0] rot_q, rot_d;
	logic             out_valid_q;
	out_word_t        out_word_q, out_d;
	logic             load_out;
	logic             out_free;
	logic             accept;
	logic             full;
	logic             empty;
	logic             last_entry;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE) && out_free;
	assign accept     = in_valid && in_ready;
	assign full       = occ_q == CNT_W'(DEPTH);
	assign empty      = occ_q == '0;
	assign last_entry = CNT_W'(rot_q) == occ_q - CNT_W'(1);
	assign out_valid  = out_valid_q;
	assign out_word   = out_word_q;
	assign occ        = occ_q;

	always_comb begin
		state_d       = state_q;
		occ_d         = occ_q;
		rot_d         = rot_q;
		load_out      = 1'b0;
		out_d         = '0;
		out_d.last    = 1'b1;
		cell_ctl.op   = CELL_HOLD;
		cell_ctl.item = in_word.item_value;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_word.cmd)
						CMD_INSERT: begin
							load_out = 1'b1;
							if (full) begin
								out_d.status = STAT_FULL;
							end else begin
								out_d.status = STAT_INSERTED;
								cell_ctl.op  = CELL_INSERT;
								occ_d        = occ_q + CNT_W'(1);
							end
						end
						CMD_REMOVE: begin
							load_out = 1'b1;
							if (empty) begin
								out_d.status = STAT_EMPTY;
							end else begin
								out_d.status       = STAT_REMOVED;
								out_d.result_value = head_val;
								cell_ctl.op        = CELL_SHIFT;
								occ_d              = occ_q - CNT_W'(1);
							end
						end
						CMD_LIST: begin
							if (empty) begin
								load_out     = 1'b1;
								out_d.status = STAT_EMPTY;
							end else begin
								state_d = ST_LIST;
								rot_d   = '0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LIST: begin
				if (out_free) begin
					load_out           = 1'b1;
					out_d.status       = STAT_LISTED;
					out_d.result_value = head_val;
					out_d.last         = last_entry;
					cell_ctl.op        = CELL_SHIFT;
					rot_d              = rot_q + ROT_W'(1);
					if (last_entry) begin
						state_d = (rot_q == ROT_W'(DEPTH - 1)) ? ST_IDLE : ST_SPIN;
					end
				end
			end
			ST_SPIN: begin
				// finish the ring rotation so the order is restored
				cell_ctl.op = CELL_SHIFT;
				rot_d       = rot_q + ROT_W'(1);
				if (rot_q == ROT_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			rot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			rot_q   <= rot_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q <= out_d;
		end
	end

`include "sorted_min_priority_queue_top_macros.svh"

	`SMPQ_ASSERT(a_occ_bound, occ_q <= CNT_W'(DEPTH), "occupancy above depth")
	`SMPQ_ASSERT_NEXT(a_insert_grows, accept && in_word.cmd == CMD_INSERT && !full, occ_q == $past(occ_q) + CNT_W'(1), "insert did not grow queue")
	`SMPQ_ASSERT_NEXT(a_remove_shrinks, accept && in_word.cmd == CMD_REMOVE && !empty, occ_q == $past(occ_q) - CNT_W'(1), "remove did not shrink queue")
	`SMPQ_ASSERT_NEXT(a_list_keeps_occ, state_q != ST_IDLE, $stable(occ_q), "occupancy changed while listing")
	`SMPQ_ASSERT(a_spin_past_entries, state_q != ST_SPIN || CNT_W'(rot_q) >= occ_q, "spin before all entries listed")

endmodule

### rtl/core/sorted_min_priority_queue_top.sv
// sorted min-priority queue of signed 32-bit words, smallest at the head
// input channel in_valid/in_ready/in_word carries a command and an item value
// output channel out_valid/out_ready/out_word carries result value, status, last
// insert and remove update the row at once: on insert every cell compares against
// the new word in parallel, and the row shifts up or down by one cell
// their single result word appears in the cycle after the input word is accepted
// list walks the ring of DEPTH cells, one entry per cycle while the receiver
// takes words; no new command is taken until the ring has rotated a full turn,
// which restores the order
// an empty remove or list gives one empty word, a full insert one full word
// unknown command codes are taken and dropped with no result
// a one-word output register holds a result while the receiver stalls; a new
// command is taken in the cycle the held word leaves
// reset empties the queue and drops any pending output word; cell contents
// are not cleared, only the occupancy count is
module sorted_min_priority_queue_top
	import smpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	cell_ctl_t          cell_ctl;
	logic [CNT_W-1:0]   occ;
	logic signed [31:0] cell_val [DEPTH];
	logic               cell_shift [DEPTH];

	smpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.head_val (cell_val[0]),
		.cell_ctl (cell_ctl),
		.occ      (occ)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left_val;
		logic               left_shift;

		if (i == 0) begin : g_head
			assign left_val   = cell_ctl.item;
			assign left_shift = 1'b0;
		end else begin : g_body
			assign left_val   = cell_val[i-1];
			assign left_shift = cell_shift[i-1];
		end

		smpq_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.occupied  (CNT_W'(i) < occ),
			.left_val  (left_val),
			.left_shift(left_shift),
			.right_val (cell_val[(i + 1) % DEPTH]),
			.val       (cell_val[i]),
			.shift     (cell_shift[i])
		);
	end

endmodule

### sim/sorted_min_priority_queue_top_tb.sv
module sorted_min_priority_queue_top_tb;
	import smpq_pkg::*;

	localparam logic [1:0]         CMD_UNUSED  = 2'd3;
	localparam logic signed [31:0] VAL_MAX     = 32'sh7fffffff;
	localparam logic signed [31:0] VAL_MIN     = 32'sh80000000;
	localparam int                 CYCLE_LIMIT = 200000;
	localparam int                 PHASE_CMDS  = 54;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_word   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	// words waiting to be sent and result words still owed by the queue
	in_word_t  cmd_words[$];
	out_word_t due_words[$];

	// shadow copy of the queue contents
	logic signed [31:0] cells[DEPTH];
	int                 fill_count = 0;

	int tx_idle     = 7;
	int rx_idle     = 68;
	int mismatches  = 0;
	int cmds_taken  = 0;
	int words_seen  = 0;
	int full_seen   = 0;
	int empty_seen  = 0;
	int cycle_count = 0;

	sorted_min_priority_queue_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic out_word_t result_word(logic signed [31:0] v, status_t s, logic l);
		out_word_t r;
		r.result_value = v;
		r.status       = s;
		r.last         = l;
		return r;
	endfunction

	// updates the shadow queue and queues the words this command owes
	function automatic void apply_command(in_word_t w);
		int i;
		logic signed [31:0] head;
		case (w.cmd)
			CMD_INSERT: begin
				if (fill_count >= DEPTH) begin
					due_words.push_back(result_word('0, STAT_FULL, 1'b1));
				end else begin
					i = fill_count;
					while (i > 0 && cells[i - 1] > w.item_value) begin
						cells[i] = cells[i - 1];
						i--;
					end
					cells[i] = w.item_value;
					fill_count++;
					due_words.push_back(result_word('0, STAT_INSERTED, 1'b1));
				end
			end
			CMD_REMOVE: begin
				if (fill_count == 0) begin
					due_words.push_back(result_word('0, STAT_EMPTY, 1'b1));
				end else begin
					head = cells[0];
					for (i = 1; i < fill_count; i++)
						cells[i - 1] = cells[i];
					fill_count--;
					due_words.push_back(result_word(head, STAT_REMOVED, 1'b1));
				end
			end
			CMD_LIST: begin
				if (fill_count == 0) begin
					due_words.push_back(result_word('0, STAT_EMPTY, 1'b1));
				end else begin
					for (i = 0; i < fill_count; i++)
						due_words.push_back(result_word(cells[i], STAT_LISTED,
							(i == fill_count - 1)));
				end
			end
			default: ;
		endcase
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				apply_command(in_word);
				cmds_taken++;
			end
			if (!in_valid || in_ready) begin
				if (cmd_words.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
					in_valid <= 1'b1;
					in_word  <= cmd_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				words_seen++;
				if (out_word.status == STAT_FULL)
					full_seen++;
				if (out_word.status == STAT_EMPTY)
					empty_seen++;
				if (due_words.size() == 0) begin
					$error("unexpected result word: value %0d status %0d last %0d",
						out_word.result_value, out_word.status, out_word.last);
					mismatches++;
				end else begin
					want = due_words.pop_front();
					if (out_word.result_value !== want.result_value) begin
						$error("result_value: expected %0d, got %0d",
							want.result_value, out_word.result_value);
						mismatches++;
					end
					if (out_word.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_word.status);
						mismatches++;
					end
					if (out_word.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_word.last);
						mismatches++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_cmd(logic [1:0] c, logic signed [31:0] v);
		in_word_t w;
		w.cmd        = c;
		w.item_value = v;
		cmd_words.push_back(w);
	endtask

	function automatic in_word_t random_word(bit fill);
		in_word_t w;
		int pick;
		int vsel;
		pick = $urandom_range(0, 99);
		vsel = $urandom_range(0, 9);
		if (pick < 3)
			w.cmd = CMD_UNUSED;
		else if (pick < (fill ? 68 : 23))
			w.cmd = CMD_INSERT;
		else if (pick < (fill ? 85 : 83))
			w.cmd = CMD_REMOVE;
		else
			w.cmd = CMD_LIST;
		if (vsel == 0)
			w.item_value = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		else if (vsel < 5)
			w.item_value = int'($urandom_range(0, 6)) - 3;
		else
			w.item_value = $urandom;
		return w;
	endfunction

	// alternating fill-heavy and drain-heavy runs so both full and empty get hit
	task automatic queue_random(int count);
		in_word_t w;
		int n;
		int run;
		bit fill;
		n    = 0;
		fill = 1'b1;
		run  = $urandom_range(8, 20);
		while (n < count) begin
			if (run == 0) begin
				fill = !fill;
				run  = $urandom_range(8, 20);
			end
			w = random_word(fill);
			cmd_words.push_back(w);
			if (w.cmd != CMD_UNUSED)
				n++;
			run--;
		end
	endtask

	task automatic wait_drained();
		while (cmd_words.size() != 0 || in_valid || due_words.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue, ignored code, then fill past full with extremes and duplicates
		push_cmd(CMD_LIST, 32'sd0);
		push_cmd(CMD_REMOVE, VAL_MAX);
		push_cmd(CMD_UNUSED, 32'sd5);
		push_cmd(CMD_INSERT, VAL_MAX);
		push_cmd(CMD_INSERT, VAL_MIN);
		push_cmd(CMD_INSERT, 32'sd0);
		push_cmd(CMD_INSERT, -32'sd1);
		push_cmd(CMD_INSERT, 32'sd0);
		push_cmd(CMD_LIST, -32'sd1);
		push_cmd(CMD_INSERT, 32'sd7);
		push_cmd(CMD_INSERT, -32'sd1);
		push_cmd(CMD_INSERT, VAL_MAX);
		push_cmd(CMD_INSERT, 32'sd1);
		push_cmd(CMD_LIST, 32'sd0);
		push_cmd(CMD_REMOVE, 32'sd0);
		push_cmd(CMD_REMOVE, 32'sd0);
		push_cmd(CMD_INSERT, VAL_MIN);
		push_cmd(CMD_LIST, 32'sd0);
		queue_random(PHASE_CMDS);
		wait_drained();

		tx_idle = 68;
		rx_idle = 7;
		queue_random(PHASE_CMDS);
		wait_drained();

		tx_idle = 0;
		rx_idle = 0;
		queue_random(PHASE_CMDS);
		wait_drained();
		repeat (DEPTH + 4) @(negedge clk);

		$display("covered %0d commands and %0d result words under three pacing mixes",
			cmds_taken, words_seen);
		$display("queue reported full %0d times and empty %0d times", full_seen, empty_seen);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/smpq_pkg.sv
rtl/core/smpq_cell.sv
rtl/core/smpq_ctrl.sv
rtl/core/sorted_min_priority_queue_top.sv
sim/sorted_min_priority_queue_top_tb.sv
